FILE: hw/rtl/beacon_trilateration_2d_core_defines.svh
// Assertion macros used by the trilateration top level.
`ifndef BEACON_TRILATERATION_2D_CORE_DEFINES_SVH
`define BEACON_TRILATERATION_2D_CORE_DEFINES_SVH
`ifndef SYNTH
// Check a property at every clock edge outside reset.
`define BTRI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("btri assertion failed");
// Check a property at every clock edge, reset included.
`define BTRI_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("btri assertion failed");
`else
`define BTRI_ASSERT(lbl, clk, rst_n, prop)
`define BTRI_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hw/rtl/btri_pkg.sv
// Package with types and constants of the trilateration core.
`timescale 1ns / 1ps
package btri_pkg;

  localparam int CRD_W   = 13;
  localparam int RNG_W   = 13;
  localparam int POS_W   = 16;
  localparam int CFG_IDX_W = 3;
  // pipeline widths
  localparam int DIF_W   = 14;   // coordinate difference
  localparam int SQD_W   = 27;   // difference of squares
  localparam int NUM_W   = 43;   // Y numerator, signed
  localparam int NMAG_W  = 42;   // Y numerator magnitude
  localparam int DEN_W   = 30;   // Y divisor magnitude
  localparam int YQ_W    = 41;   // Y quotient magnitude
  localparam int Y_W     = 42;   // signed Y
  localparam int XN_W    = 59;   // X numerator, signed
  localparam int DX_W    = 15;   // X divisor
  localparam int XQ_W    = 16;   // X quotient magnitude

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AX = 3'd0,
    CFG_AY = 3'd1,
    CFG_BX = 3'd2,
    CFG_BY = 3'd3,
    CFG_CX = 3'd4,
    CFG_CY = 3'd5
  } btri_cfg_idx_t;

  typedef struct packed {
    logic [RNG_W-1:0] range_a;
    logic [RNG_W-1:0] range_b;
    logic [RNG_W-1:0] range_c;
  } btri_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    degenerate;
    logic                    saturated;
  } btri_out_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] ax;
    logic signed [CRD_W-1:0] ay;
    logic signed [CRD_W-1:0] bx;
    logic signed [CRD_W-1:0] by;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
  } btri_geom_t;

  localparam btri_geom_t GEOM_RST = '{ax: 13'sd0, ay: 13'sd0, bx: 13'sd1,
                                      by: 13'sd10, cx: 13'sd10, cy: 13'sd2};

  // Carried alongside the Y division
  typedef struct packed {
    logic                    neg;
    logic                    degen;
    logic signed [SQD_W-1:0] dab;
    logic signed [SQD_W-1:0] kb;
    logic signed [DIF_W-1:0] gy;
    logic signed [DX_W-1:0]  dx;
  } btri_yside_t;

  // Carried alongside the X division
  typedef struct packed {
    logic                  neg;
    logic                  big;
    logic                  degen;
    logic signed [Y_W-1:0] y;
  } btri_xside_t;

  localparam logic signed [Y_W-1:0] Y_MAX = 42'sd32767;
  localparam logic signed [Y_W-1:0] Y_MIN = -42'sd32768;
  localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7FFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;

endpackage

FILE: hw/rtl/btri_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
module btri_div #(
  parameter int NW = 42,
  parameter int DW = 30,
  parameter int QW = 41,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [NW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic          vld_r  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;
    logic [NW-1:0]    rem_in;
    logic [DW-1:0]    den_in;
    logic [QW-1:0]    quo_in;
    logic [SW-1:0]    side_in;
    logic             vld_in;
    logic [NW+DW-1:0] rem_ext;
    logic [NW+DW-1:0] dsh;
    logic             hit;
    logic [NW-1:0]    rem_nxt;
    logic [QW-1:0]    quo_nxt;

    if (s == 0) begin : g_first
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign den_in  = den_r[s-1];
      assign quo_in  = quo_r[s-1];
      assign side_in = side_r[s-1];
      assign vld_in  = vld_r[s-1];
    end

    // Try to subtract the shifted divisor for this quotient bit
    assign rem_ext = (NW+DW)'(rem_in);
    assign dsh     = (NW+DW)'(den_in) << K;
    assign hit     = (rem_ext >= dsh);
    assign rem_nxt = hit ? (rem_in - dsh[NW-1:0]) : rem_in;
    assign quo_nxt = hit ? (quo_in | (QW'(1) << K)) : quo_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        den_r[s]  <= den_in;
        quo_r[s]  <= quo_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_quo  = quo_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

FILE: hw/rtl/btri_front.sv
// Front stages: squares, differences, products, Y numerator and divisor.
`timescale 1ns / 1ps
module btri_front
  import btri_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  btri_in_t          in_data,
  input  btri_geom_t        geom,
  output logic              out_vld,
  output logic [NMAG_W-1:0] out_nmag,
  output logic [DEN_W-1:0]  out_dmag,
  output btri_yside_t       out_side
);

  // stage 1
  logic                    v1_r;
  logic signed [SQD_W-1:0] dab_r, dac_r, kb_r, kc_r;
  logic signed [DIF_W-1:0] ex_r, fx_r, gy_r, hy_r;
  logic [25:0]             sa, sb, sc;
  logic signed [25:0]      ax2, ay2, bx2, by2, cx2, cy2;
  logic signed [SQD_W-1:0] dab_nxt, dac_nxt, kb_nxt, kc_nxt;
  logic signed [DIF_W-1:0] ex_nxt, fx_nxt, gy_nxt, hy_nxt;

  // stage 2
  logic                    v2_r;
  logic signed [40:0]      pp1_r, pp2_r, pp3_r, pp4_r;
  logic signed [27:0]      pp5_r, pp6_r;
  logic signed [SQD_W-1:0] dab2_r, kb2_r;
  logic signed [DIF_W-1:0] ex2_r, gy2_r;

  // stage 3
  logic                    v3_r;
  logic [NMAG_W-1:0]       nmag_r;
  logic [DEN_W-1:0]        dmag_r;
  btri_yside_t             side_r;
  logic signed [NUM_W-1:0] num;
  logic signed [28:0]      ddiff;
  logic signed [DEN_W-1:0] dd;
  logic [NUM_W-1:0]        nabs;
  logic [DEN_W-1:0]        dabs;
  btri_yside_t             side_nxt;

  // Square ranges and beacon coordinates, take differences
  always_comb begin
    sa = 26'(in_data.range_a) * 26'(in_data.range_a);
    sb = 26'(in_data.range_b) * 26'(in_data.range_b);
    sc = 26'(in_data.range_c) * 26'(in_data.range_c);
    ax2 = 26'(geom.ax) * 26'(geom.ax);
    ay2 = 26'(geom.ay) * 26'(geom.ay);
    bx2 = 26'(geom.bx) * 26'(geom.bx);
    by2 = 26'(geom.by) * 26'(geom.by);
    cx2 = 26'(geom.cx) * 26'(geom.cx);
    cy2 = 26'(geom.cy) * 26'(geom.cy);
    dab_nxt = $signed({1'b0, sa}) - $signed({1'b0, sb});
    dac_nxt = $signed({1'b0, sa}) - $signed({1'b0, sc});
    ex_nxt = DIF_W'(geom.bx) - DIF_W'(geom.ax);
    fx_nxt = DIF_W'(geom.cx) - DIF_W'(geom.ax);
    gy_nxt = DIF_W'(geom.by) - DIF_W'(geom.ay);
    hy_nxt = DIF_W'(geom.cy) - DIF_W'(geom.ay);
    kb_nxt = SQD_W'(ax2) + SQD_W'(ay2) - SQD_W'(bx2) - SQD_W'(by2);
    kc_nxt = SQD_W'(ax2) + SQD_W'(ay2) - SQD_W'(cx2) - SQD_W'(cy2);
  end

  // Combine products into the Y numerator and divisor
  always_comb begin
    num = NUM_W'(pp1_r) - NUM_W'(pp2_r) + NUM_W'(pp3_r) - NUM_W'(pp4_r);
    ddiff = 29'(pp5_r) - 29'(pp6_r);
    dd = {ddiff, 1'b0};
    nabs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    dabs = dd[DEN_W-1] ? DEN_W'(-dd) : DEN_W'(dd);
    side_nxt.neg   = num[NUM_W-1] ^ dd[DEN_W-1];
    side_nxt.degen = (ddiff == '0) || (ex2_r == '0);
    side_nxt.dab   = dab2_r;
    side_nxt.kb    = kb2_r;
    side_nxt.gy    = gy2_r;
    side_nxt.dx    = {ex2_r, 1'b0};
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      dab_r  <= dab_nxt;
      dac_r  <= dac_nxt;
      kb_r   <= kb_nxt;
      kc_r   <= kc_nxt;
      ex_r   <= ex_nxt;
      fx_r   <= fx_nxt;
      gy_r   <= gy_nxt;
      hy_r   <= hy_nxt;
      pp1_r  <= 41'(dab_r) * 41'(fx_r);
      pp2_r  <= 41'(dac_r) * 41'(ex_r);
      pp3_r  <= 41'(ex_r) * 41'(kc_r);
      pp4_r  <= 41'(fx_r) * 41'(kb_r);
      pp5_r  <= 28'(gy_r) * 28'(fx_r);
      pp6_r  <= 28'(hy_r) * 28'(ex_r);
      dab2_r <= dab_r;
      kb2_r  <= kb_r;
      ex2_r  <= ex_r;
      gy2_r  <= gy_r;
      nmag_r <= nabs[NMAG_W-1:0];
      dmag_r <= dabs;
      side_r <= side_nxt;
    end
  end

  assign out_vld  = v3_r;
  assign out_nmag = nmag_r;
  assign out_dmag = dmag_r;
  assign out_side = side_r;

endmodule

FILE: hw/rtl/beacon_trilateration_2d_core.sv
// Top level of the three-beacon 2D trilateration core.
//
// Usage: write the six beacon coordinates through cfg_we / cfg_idx /
// cfg_wdata (index 0..5 = a_x, a_y, b_x, b_y, c_x, c_y; other indexes are
// ignored) while no item is in flight. Each item on in_data carries three
// ranges; one result item per input appears on out_data.
// Path from input accept to out_valid: 3 front stages, 41 stages of the Y
// divider, 4 stages for the X numerator, 16 stages of the X divider, one
// output register. Throughput: one item per cycle while the receiver does not
// stall; the bit-per-stage dividers set the depth, not the rate.
// Reset loads the default beacon layout and empties the pipeline.
// When the receiver stalls (out_valid high, out_ready low) the whole pipeline
// holds and in_ready drops; nothing is lost or repeated.
// degenerate flags a zero divisor and forces zero positions; saturated flags
// a coordinate clamped to the 16-bit range.
`timescale 1ns / 1ps
`include "beacon_trilateration_2d_core_defines.svh"
module beacon_trilateration_2d_core
  import btri_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  btri_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output btri_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CRD_W-1:0]     cfg_wdata
);

  btri_geom_t        geom_r;
  logic              adv;

  logic              f_vld;
  logic [NMAG_W-1:0] f_nmag;
  logic [DEN_W-1:0]  f_dmag;
  btri_yside_t       f_side;

  logic              yd_vld;
  logic [YQ_W-1:0]   yd_quo;
  btri_yside_t       yd_side;

  // Y sign, X numerator, X magnitude stages
  logic                    y_vld_r, p_vld_r, n_vld_r, m_vld_r;
  logic signed [Y_W-1:0]   y_r, py_r, ny_r;
  btri_yside_t             ys_r, ps_r;
  logic signed [35:0]      plo_r;
  logic signed [34:0]      phi_r;
  logic signed [XN_W-1:0]  xn_r;
  logic signed [DX_W-1:0]  ndx_r;
  logic                    ndeg_r;
  logic [XN_W-1:0]         xm_r;
  logic [DX_W-1:0]         dxm_r;
  btri_xside_t             ms_r;

  logic signed [Y_W-1:0]   y_nxt;
  logic signed [XN_W-1:0]  prod, xn_nxt;
  logic [XN_W-1:0]         xabs;
  logic [DX_W-1:0]         dxabs;
  logic                    big;
  btri_xside_t             ms_nxt;

  logic              xd_vld;
  logic [XQ_W-1:0]   xd_quo;
  btri_xside_t       xd_side;

  logic              out_valid_r;
  btri_out_t         out_data_r;
  btri_out_t         out_nxt;

  // Whole pipeline moves unless a result waits
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Beacon coordinate registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r <= GEOM_RST;
    end else if (cfg_we) begin
      case (btri_cfg_idx_t'(cfg_idx))
        CFG_AX:  geom_r.ax <= cfg_wdata;
        CFG_AY:  geom_r.ay <= cfg_wdata;
        CFG_BX:  geom_r.bx <= cfg_wdata;
        CFG_BY:  geom_r.by <= cfg_wdata;
        CFG_CX:  geom_r.cx <= cfg_wdata;
        CFG_CY:  geom_r.cy <= cfg_wdata;
        default: geom_r <= geom_r;
      endcase
    end
  end

  btri_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (in_valid),
    .in_data  (in_data),
    .geom     (geom_r),
    .out_vld  (f_vld),
    .out_nmag (f_nmag),
    .out_dmag (f_dmag),
    .out_side (f_side)
  );

  btri_div #(
    .NW (NMAG_W),
    .DW (DEN_W),
    .QW (YQ_W),
    .SW ($bits(btri_yside_t))
  ) u_ydiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (f_vld),
    .in_num   (f_nmag),
    .in_den   (f_dmag),
    .in_side  (f_side),
    .out_vld  (yd_vld),
    .out_quo  (yd_quo),
    .out_side (yd_side)
  );

  // Apply sign to Y; form X numerator and its magnitude
  always_comb begin
    y_nxt = yd_side.neg ? -$signed({1'b0, yd_quo}) : $signed({1'b0, yd_quo});
    prod = (XN_W'(phi_r) <<< 21) + XN_W'(plo_r);
    xn_nxt = XN_W'(ps_r.dab) - XN_W'(ps_r.kb) - (prod <<< 1);
    xabs = xn_r[XN_W-1] ? XN_W'(-xn_r) : XN_W'(xn_r);
    dxabs = ndx_r[DX_W-1] ? DX_W'(-ndx_r) : DX_W'(ndx_r);
    big = (xabs >= (XN_W'(dxabs) << XQ_W));
    ms_nxt.neg   = xn_r[XN_W-1] ^ ndx_r[DX_W-1];
    ms_nxt.big   = big;
    ms_nxt.degen = ndeg_r;
    ms_nxt.y     = ny_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_vld_r <= 1'b0;
      p_vld_r <= 1'b0;
      n_vld_r <= 1'b0;
      m_vld_r <= 1'b0;
    end else if (adv) begin
      y_vld_r <= yd_vld;
      p_vld_r <= y_vld_r;
      n_vld_r <= p_vld_r;
      m_vld_r <= n_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y_r    <= y_nxt;
      ys_r   <= yd_side;
      // split 14 x 42 product into two partial products
      plo_r  <= 36'(ys_r.gy) * $signed({15'd0, y_r[20:0]});
      phi_r  <= 35'(ys_r.gy) * 35'($signed(y_r[Y_W-1:21]));
      py_r   <= y_r;
      ps_r   <= ys_r;
      xn_r   <= xn_nxt;
      ndx_r  <= ps_r.dx;
      ndeg_r <= ps_r.degen;
      ny_r   <= py_r;
      xm_r   <= big ? '0 : xabs;
      dxm_r  <= dxabs;
      ms_r   <= ms_nxt;
    end
  end

  btri_div #(
    .NW (XN_W),
    .DW (DX_W),
    .QW (XQ_W),
    .SW ($bits(btri_xside_t))
  ) u_xdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (m_vld_r),
    .in_num   (xm_r),
    .in_den   (dxm_r),
    .in_side  (ms_r),
    .out_vld  (xd_vld),
    .out_quo  (xd_quo),
    .out_side (xd_side)
  );

  // Clamp both coordinates, zero on degenerate geometry
  always_comb begin
    out_nxt = '0;
    if (xd_side.degen) begin
      out_nxt.degenerate = 1'b1;
    end else begin
      if (xd_side.big) begin
        out_nxt.saturated = 1'b1;
        out_nxt.pos_x = xd_side.neg ? POS_MIN : POS_MAX;
      end else if (!xd_side.neg) begin
        if (xd_quo[XQ_W-1]) begin
          out_nxt.saturated = 1'b1;
          out_nxt.pos_x = POS_MAX;
        end else begin
          out_nxt.pos_x = $signed(xd_quo);
        end
      end else begin
        if (xd_quo > 16'd32768) begin
          out_nxt.saturated = 1'b1;
          out_nxt.pos_x = POS_MIN;
        end else begin
          out_nxt.pos_x = $signed(POS_W'(17'd0 - {1'b0, xd_quo}));
        end
      end
      if (xd_side.y > Y_MAX) begin
        out_nxt.saturated = 1'b1;
        out_nxt.pos_y = POS_MAX;
      end else if (xd_side.y < Y_MIN) begin
        out_nxt.saturated = 1'b1;
        out_nxt.pos_y = POS_MIN;
      end else begin
        out_nxt.pos_y = xd_side.y[POS_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= xd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BTRI_ASSERT(a_degen_zero, clk, rst_n, out_valid && out_data.degenerate |-> out_data.pos_x == 16'sd0 && out_data.pos_y == 16'sd0 && !out_data.saturated)
  `BTRI_ASSERT(a_sat_bound, clk, rst_n, out_valid && out_data.saturated |-> out_data.pos_x == POS_MAX || out_data.pos_x == POS_MIN || out_data.pos_y == POS_MAX || out_data.pos_y == POS_MIN)
  `BTRI_ASSERT(a_stall_hold, clk, rst_n, !adv |=> $stable(y_r) && $stable(y_vld_r) && $stable(xm_r))
  `BTRI_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid && !y_vld_r && !m_vld_r)

endmodule

FILE: sim/btri_checker.sv
// Checker for the trilateration core: tracks geometry, predicts positions, compares.
`timescale 1ns / 1ps
module btri_checker
  import btri_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  btri_in_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  btri_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CRD_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending,
  output int                   done_count
);

  btri_geom_t geom;
  btri_out_t  expected_pos_q[$];

  // Clamp one coordinate to the 16-bit output range
  function automatic logic signed [POS_W-1:0] clamp_pos(longint v, ref bit sat);
    if (v > 32767) begin
      sat = 1'b1;
      return POS_MAX;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return POS_MIN;
    end
    return v[POS_W-1:0];
  endfunction

  // Solve the linearised circle equations for one range triple
  function automatic btri_out_t locate(btri_geom_t g, btri_in_t r);
    longint ax, ay, bx, by, cx, cy, ra, rb, rc;
    longint dab, dac, p, q, d, dx, y, xn, x;
    bit sat;
    btri_out_t res;
    ax = longint'(g.ax); ay = longint'(g.ay);
    bx = longint'(g.bx); by = longint'(g.by);
    cx = longint'(g.cx); cy = longint'(g.cy);
    ra = longint'(r.range_a); rb = longint'(r.range_b); rc = longint'(r.range_c);
    dab = ra * ra - rb * rb;
    dac = ra * ra - rc * rc;
    p = dab * (cx - ax) - dac * (bx - ax);
    q = (bx - ax) * (ax * ax - cx * cx + ay * ay - cy * cy)
      - (cx - ax) * (ax * ax - bx * bx + ay * ay - by * by);
    d = 2 * ((by - ay) * (cx - ax) - (cy - ay) * (bx - ax));
    dx = 2 * (bx - ax);
    sat = 1'b0;
    res = '0;
    if (d == 0 || dx == 0) begin
      res.degenerate = 1'b1;
    end else begin
      y = (p + q) / d;
      xn = dab - 2 * (by - ay) * y - ax * ax + bx * bx - ay * ay + by * by;
      x = xn / dx;
      res.pos_x = clamp_pos(x, sat);
      res.pos_y = clamp_pos(y, sat);
      res.saturated = sat;
    end
    return res;
  endfunction

  assign pending = expected_pos_q.size();

  // Follow register writes, queue predictions, check results
  always @(posedge clk) begin
    btri_out_t want;
    if (!rst_n) begin
      geom <= GEOM_RST;
      fail_count <= 0;
      done_count <= 0;
      expected_pos_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_AX: geom.ax <= cfg_wdata;
          CFG_AY: geom.ay <= cfg_wdata;
          CFG_BX: geom.bx <= cfg_wdata;
          CFG_BY: geom.by <= cfg_wdata;
          CFG_CX: geom.cx <= cfg_wdata;
          CFG_CY: geom.cy <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_pos_q.push_back(locate(geom, in_data));
      if (out_valid && out_ready) begin
        done_count <= done_count + 1;
        if (expected_pos_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result x=%0d y=%0d deg=%0b sat=%0b", out_data.pos_x,
                     out_data.pos_y, out_data.degenerate, out_data.saturated);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pos_q.pop_front();
          if (want !== out_data) begin
            if (fail_count < 10)
              $display("mismatch: want x=%0d y=%0d deg=%0b sat=%0b, got x=%0d y=%0d deg=%0b sat=%0b",
                       want.pos_x, want.pos_y, want.degenerate, want.saturated,
                       out_data.pos_x, out_data.pos_y, out_data.degenerate,
                       out_data.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: sim/tb.sv
// Testbench top: stimulus, geometry sweeps and verdict for the trilateration core.
`timescale 1ns / 1ps
module tb
  import btri_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 600000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  btri_in_t in_data;
  btri_out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CRD_W-1:0] cfg_wdata;
  int fail_count, pending, done_count;
  int cycles;
  bit calm;
  btri_geom_t cur_geom;

  beacon_trilateration_2d_core u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_idx, .cfg_wdata
  );

  btri_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_idx, .cfg_wdata, .fail_count, .pending, .done_count
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, steady at the end
  initial begin
    int n;
    bit pressed;
    out_ready = 1'b0;
    pressed = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!pressed && done_count > 580) begin
        pressed = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 30);
        out_ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Offer one item; hold it until accepted
  task automatic send_ranges(logic [RNG_W-1:0] ra, logic [RNG_W-1:0] rb,
                             logic [RNG_W-1:0] rc);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{range_a: ra, range_b: rb, range_c: rc};
    do @(posedge clk); while (!in_ready);
  endtask

  // Load a new beacon layout once the pipeline has drained
  task automatic load_geometry(btri_geom_t g);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cur_geom = g;
    cfg_we <= 1'b1;
    for (int i = 0; i < 7; i++) begin
      case (i)
        0: begin cfg_idx <= CFG_AX; cfg_wdata <= g.ax; end
        1: begin cfg_idx <= CFG_AY; cfg_wdata <= g.ay; end
        2: begin cfg_idx <= CFG_BX; cfg_wdata <= g.bx; end
        3: begin cfg_idx <= CFG_BY; cfg_wdata <= g.by; end
        4: begin cfg_idx <= CFG_CX; cfg_wdata <= g.cx; end
        5: begin cfg_idx <= CFG_CY; cfg_wdata <= g.cy; end
        default: begin cfg_idx <= CFG_UNUSED; cfg_wdata <= CRD_W'($urandom); end
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [RNG_W-1:0] dist_to(real px, real py, logic signed [CRD_W-1:0] bx,
                                               logic signed [CRD_W-1:0] by);
    real d;
    d = $sqrt((px - bx) * (px - bx) + (py - by) * (py - by)) + 0.5;
    if (d > 8191.0) return 13'd8191;
    return RNG_W'(int'($floor(d)));
  endfunction

  // Mostly ranges that fit a real point, some noise
  task automatic random_burst(int count);
    real px, py;
    int span;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        span = ($urandom_range(0, 3) == 0) ? 6000 : 200;
        px = real'($signed($urandom_range(0, 2 * span)) - span);
        py = real'($signed($urandom_range(0, 2 * span)) - span);
        send_ranges(dist_to(px, py, cur_geom.ax, cur_geom.ay),
                    dist_to(px, py, cur_geom.bx, cur_geom.by),
                    dist_to(px, py, cur_geom.cx, cur_geom.cy));
      end else begin
        send_ranges(RNG_W'($urandom), RNG_W'($urandom), RNG_W'($urandom));
      end
    end
  endtask

  function automatic btri_geom_t random_geometry(int span);
    btri_geom_t g;
    g.ax = CRD_W'($signed($urandom_range(0, 2 * span)) - span);
    g.ay = CRD_W'($signed($urandom_range(0, 2 * span)) - span);
    g.bx = CRD_W'($signed($urandom_range(0, 2 * span)) - span);
    g.by = CRD_W'($signed($urandom_range(0, 2 * span)) - span);
    g.cx = CRD_W'($signed($urandom_range(0, 2 * span)) - span);
    g.cy = CRD_W'($signed($urandom_range(0, 2 * span)) - span);
    return g;
  endfunction

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    cur_geom = GEOM_RST;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset layout, range extremes
    send_ranges(13'd0, 13'd0, 13'd0);
    send_ranges(13'd8191, 13'd8191, 13'd8191);
    send_ranges(13'd8191, 13'd0, 13'd0);
    send_ranges(13'd0, 13'd8191, 13'd8191);
    send_ranges(13'd0, 13'd8191, 13'd0);
    send_ranges(13'd0, 13'd0, 13'd8191);
    send_ranges(13'd5, 13'd4, 13'd8);
    send_ranges(13'd4096, 13'd2048, 13'd1);
    random_burst(200);

    // Extreme corners
    load_geometry('{ax: -13'sd4096, ay: -13'sd4096, bx: 13'sd4095, by: -13'sd4096,
                    cx: -13'sd4096, cy: 13'sd4095});
    send_ranges(13'd0, 13'd0, 13'd0);
    send_ranges(13'd8191, 13'd8191, 13'd8191);
    send_ranges(13'd8191, 13'd0, 13'd8191);
    random_burst(220);

    // Second beacon straight above the first: x divisor is zero
    load_geometry('{ax: 13'sd100, ay: 13'sd0, bx: 13'sd100, by: 13'sd50,
                    cx: 13'sd300, cy: 13'sd20});
    send_ranges(13'd10, 13'd20, 13'd30);
    random_burst(40);

    // Collinear beacons: y divisor is zero
    load_geometry('{ax: 13'sd0, ay: 13'sd0, bx: 13'sd10, by: 13'sd10,
                    cx: 13'sd20, cy: 13'sd20});
    send_ranges(13'd10, 13'd20, 13'd30);
    random_burst(40);

    // Opposite extremes
    load_geometry('{ax: 13'sd4095, ay: 13'sd4095, bx: -13'sd4096, by: 13'sd4095,
                    cx: 13'sd4095, cy: -13'sd4096});
    random_burst(200);

    // Random layouts, small and wide
    for (int k = 0; k < 6; k++) begin
      load_geometry(random_geometry((k % 2 == 0) ? 60 : 4095));
      if (k == 5) calm = 1'b1;
      random_burst(160);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
